### design/lpns_pkg.sv
// lpns_pkg: shared constants, types and helpers for the length prefixed nal splitter
// no dependencies; used by length_prefixed_nal_splitter and lpns_checker
package lpns_pkg;

    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 32;
    localparam int TYPE_W   = 5;
    localparam int CFG_W    = 3;
    localparam int PHASE_W  = 2;

    localparam logic [CFG_W-1:0]  CFG_RESET = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_MASK = 5'h1f;

    localparam logic STATUS_FOUND   = 1'b0;
    localparam logic STATUS_BAD_LEN = 1'b1;

    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        count_t                unit_length;
        logic [TYPE_W-1:0]     unit_type;
        count_t                payload_offset;
        logic                  status;
    } result_t;

    // prefix width in bytes: 0 acts as 1, 5..7 act as 4
    function automatic logic [CFG_W-1:0] prefix_width(input logic [CFG_W-1:0] cfg);
        logic [CFG_W-1:0] w;
        w = cfg;
        if (cfg == 3'd0) begin
            w = 3'd1;
        end else if (cfg > 3'd4) begin
            w = 3'd4;
        end
        return w;
    endfunction

endpackage

### design/length_prefixed_nal_splitter.sv
// length_prefixed_nal_splitter: top level, parses length prefixed nal units from a byte stream
// depends on lpns_pkg
//
// Takes one byte of a video sample per word and reports, for each nal unit, its length
// prefix value, its type and the offset of its payload; a zero length or one that runs
// past the sample gives one error word and the rest of the sample is skipped. A byte can
// be accepted in every cycle unless the result output stalls, so the sustained rate is one
// byte per clock. Each byte passes through an input register and a result register: a result
// word and the parser state are updated as its byte leaves the input register. The prefix
// width register is written through cfg_wr_en / cfg_wr_data and takes effect once registered.
module length_prefixed_nal_splitter (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [lpns_pkg::CFG_W-1:0]        cfg_wr_data,
    // byte input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lpns_pkg::DATA_W-1:0]       s_data_byte,
    input  logic                              s_first_of_sample,
    input  logic [lpns_pkg::COUNT_W-1:0]      s_sample_bytes,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lpns_pkg::COUNT_W-1:0]      m_unit_length,
    output logic [lpns_pkg::TYPE_W-1:0]       m_unit_type,
    output logic [lpns_pkg::COUNT_W-1:0]      m_payload_offset,
    output logic                              m_status
);

    localparam logic [lpns_pkg::PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [lpns_pkg::PHASE_W-1:0] PH_PREFIX = 2'd1;
    localparam logic [lpns_pkg::PHASE_W-1:0] PH_FIRST  = 2'd2;
    localparam logic [lpns_pkg::PHASE_W-1:0] PH_SKIP   = 2'd3;

    // configuration register
    logic [lpns_pkg::CFG_W-1:0]  cfg_reg;
    logic [lpns_pkg::CFG_W-1:0]  width;

    // input register
    logic                              in_valid_reg;
    logic [lpns_pkg::DATA_W-1:0]       in_byte_reg;
    logic                              in_first_reg;
    lpns_pkg::count_t                  in_size_reg;

    // parser state
    logic [lpns_pkg::PHASE_W-1:0]      phase_reg, phase_next;
    lpns_pkg::count_t                  acc_reg, acc_next;
    logic [lpns_pkg::CFG_W-1:0]        seen_reg, seen_next;
    lpns_pkg::count_t                  left_reg, left_next;
    lpns_pkg::count_t                  pay_reg, pay_next;
    lpns_pkg::count_t                  pos_reg, pos_next;

    // result register
    logic                              out_valid_reg;
    lpns_pkg::result_t                 out_reg;

    logic                              advance;
    logic                              emit;
    lpns_pkg::result_t                 res;

    // state as seen by this byte, after a possible sample restart
    logic [lpns_pkg::PHASE_W-1:0]      ph;
    lpns_pkg::count_t                  acc, left, pay, pos;
    logic [lpns_pkg::CFG_W-1:0]        seen;
    lpns_pkg::count_t                  acc_sh, left_dec, pos_inc, pay_dec, len_m1;
    logic [lpns_pkg::CFG_W-1:0]        seen_inc;

    assign width   = lpns_pkg::prefix_width(cfg_reg);
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= lpns_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_first_reg <= s_first_of_sample;
            in_size_reg  <= s_sample_bytes;
        end
    end

    always_comb begin
        if (in_first_reg) begin
            left = in_size_reg;
            pos  = '0;
            pay  = '0;
            acc  = '0;
            seen = '0;
            ph   = (in_size_reg > lpns_pkg::count_t'(width)) ? PH_PREFIX : PH_IDLE;
        end else begin
            left = left_reg;
            pos  = pos_reg;
            pay  = pay_reg;
            acc  = acc_reg;
            seen = seen_reg;
            ph   = phase_reg;
        end

        acc_sh   = {acc[lpns_pkg::COUNT_W-lpns_pkg::DATA_W-1:0], in_byte_reg};
        seen_inc = seen + 3'd1;
        left_dec = left - 32'd1;
        pos_inc  = pos + 32'd1;
        pay_dec  = pay - 32'd1;
        len_m1   = acc - 32'd1;

        phase_next = ph;
        acc_next   = acc;
        seen_next  = seen;
        left_next  = left;
        pay_next   = pay;
        pos_next   = pos;
        emit       = 1'b0;
        res        = '0;

        unique case (ph)
            PH_PREFIX: begin
                acc_next  = acc_sh;
                seen_next = seen_inc;
                left_next = left_dec;
                pos_next  = pos_inc;
                if (seen_inc >= width) begin
                    if (acc_sh == '0 || acc_sh > left_dec) begin
                        emit               = 1'b1;
                        res.unit_length    = acc_sh;
                        res.unit_type      = '0;
                        res.payload_offset = pos_inc;
                        res.status         = lpns_pkg::STATUS_BAD_LEN;
                        phase_next         = PH_IDLE;
                    end else begin
                        phase_next = PH_FIRST;
                    end
                end
            end
            PH_FIRST: begin
                emit               = 1'b1;
                res.unit_length    = acc;
                res.unit_type      = in_byte_reg[lpns_pkg::TYPE_W-1:0] & lpns_pkg::TYPE_MASK;
                res.payload_offset = pos;
                res.status         = lpns_pkg::STATUS_FOUND;
                pay_next           = len_m1;
                left_next          = left_dec;
                pos_next           = pos_inc;
                if (len_m1 == '0) begin
                    acc_next   = '0;
                    seen_next  = '0;
                    phase_next = (left_dec > lpns_pkg::count_t'(width)) ? PH_PREFIX : PH_IDLE;
                end else begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP: begin
                pay_next  = pay_dec;
                left_next = left_dec;
                pos_next  = pos_inc;
                if (pay_dec == '0) begin
                    acc_next   = '0;
                    seen_next  = '0;
                    phase_next = (left_dec > lpns_pkg::count_t'(width)) ? PH_PREFIX : PH_IDLE;
                end
            end
            default: begin
                // idle: byte ignored
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            seen_reg  <= '0;
            left_reg  <= '0;
            pay_reg   <= '0;
            pos_reg   <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            left_reg  <= left_next;
            pay_reg   <= pay_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_unit_length    = out_reg.unit_length;
    assign m_unit_type      = out_reg.unit_type;
    assign m_payload_offset = out_reg.payload_offset;
    assign m_status         = out_reg.status;

endmodule

### design/lpns_checker.sv
// lpns_checker: port level assertions for length_prefixed_nal_splitter, with its bind
// depends on lpns_pkg and the top level's ports
module lpns_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_ready,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [lpns_pkg::COUNT_W-1:0]      m_unit_length,
    input  logic [lpns_pkg::TYPE_W-1:0]       m_unit_type,
    input  logic [lpns_pkg::COUNT_W-1:0]      m_payload_offset,
    input  logic                              m_status
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_unit_length) && $stable(m_unit_type)
            && $stable(m_payload_offset) && $stable(m_status))
        else $error("result word changed while stalled");

    // error words carry no type
    a_err_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == lpns_pkg::STATUS_BAD_LEN |-> m_unit_type == '0)
        else $error("error word with nonzero type");

    // a found unit always has a nonzero length and sits past its prefix
    a_found_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == lpns_pkg::STATUS_FOUND |-> m_unit_length != '0
            && m_payload_offset != '0)
        else $error("found unit with zero length or zero offset");

    // with no result waiting, input is never blocked
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

endmodule

bind length_prefixed_nal_splitter lpns_checker u_lpns_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_unit_length    (m_unit_length),
    .m_unit_type      (m_unit_type),
    .m_payload_offset (m_payload_offset),
    .m_status         (m_status)
);
